@@ hdl/lpct_pkg.sv @@
// ============================================================================
// lpct_pkg
// Shared types and constants of the load prediction check table.
// ============================================================================
package lpct_pkg;

   localparam int DEFAULT_ENTRIES   = 64;
   localparam int DEFAULT_LINE_BITS = 6;

   localparam int ADDR_W   = 64;
   localparam int UOP_W    = 64;
   localparam int LNUM_W   = 64;
   localparam int DIST_W   = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   localparam logic [DIST_W-1:0] DIST_RESET = 32'd64;

   // entries counted per cycle by the removal sweep
   localparam int CHUNK_W = 8;
   localparam int PC_W    = $clog2(CHUNK_W + 1);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT     = 2'd0,
      OP_CHECK      = 2'd1,
      OP_INVALIDATE = 2'd2,
      OP_CLEANUP    = 2'd3
   } req_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED    = 3'd0,
      ST_REFRESHED   = 3'd1,
      ST_FULL        = 3'd2,
      ST_MATCH       = 3'd3,
      ST_NO_ENTRY    = 3'd4,
      ST_WRONG_BLOCK = 3'd5,
      ST_REMOVED     = 3'd6
   } rsp_status_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch request payload
      logic compare;   // register per-entry match vectors
      logic resolve;   // apply table update, form result
      logic sweep;     // count one chunk of removed entries
      logic push;      // load response register
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic bulk;        // request removes a set of entries
      logic sweep_last;  // final sweep chunk this cycle
      logic slot_free;   // response register can take a result
   } dp_stat_type;

endpackage

@@ hdl/lpct_if.sv @@
// ============================================================================
// lpct_if
// Valid/ready channels of the load prediction check table.
// ============================================================================
interface lpct_req_if import lpct_pkg::*;;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     req_type;
   logic [ADDR_W-1:0]   predicted_addr;
   logic [ADDR_W-1:0]   actual_addr;
   logic [UOP_W-1:0]    producer_uop;
   logic [LNUM_W-1:0]   load_number;

   modport source (output valid, req_type, predicted_addr, actual_addr,
                   producer_uop, load_number, input ready);
   modport sink   (input valid, req_type, predicted_addr, actual_addr,
                   producer_uop, load_number, output ready);
endinterface

interface lpct_rsp_if import lpct_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  removed_count;
   logic [COUNT_W-1:0]  live_count;

   modport source (output valid, status, removed_count, live_count, input ready);
   modport sink   (input valid, status, removed_count, live_count, output ready);
endinterface

interface lpct_csr_if import lpct_pkg::*;;
   logic                valid;
   logic                ready;
   logic [DIST_W-1:0]   fusion_distance;

   modport source (output valid, fusion_distance, input ready);
   modport sink   (input valid, fusion_distance, output ready);
endinterface

@@ hdl/load_prediction_check_table.sv @@
// ============================================================================
// load_prediction_check_table
// Table of predicted cache blocks keyed by block and producer micro-op,
// with insert, check-and-consume, invalidate and stale cleanup requests.
// ============================================================================
//
//  Channel   Dir  Transfer carries
//  --------  ---  -------------------------------------------------------------
//  req_bus   in   req_type, predicted_addr, actual_addr, producer_uop,
//                 load_number
//  rsp_bus   out  status, removed_count, live_count (one per request)
//  csr_bus   in   fusion_distance (always ready)
//
//  Insert, check and single-entry invalidate go through compare and resolve;
//  the next one enters in the cycle the result moves to the response register.
//  Bulk invalidate (micro-op zero) and cleanup also pass the sweep state:
//  the removed count is summed eight entries per cycle by the sweep counter.
//  Reset empties the table at once (valid bits clear); no clearing pass.
//  With rsp_bus stalled, one finished result waits inside while the response
//  register holds the previous one; the request side stalls behind it.
// ============================================================================
module load_prediction_check_table import lpct_pkg::*; #(
   parameter int ENTRIES   = DEFAULT_ENTRIES,
   parameter int LINE_BITS = DEFAULT_LINE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   lpct_req_if.sink    req_bus,
   lpct_rsp_if.source  rsp_bus,
   lpct_csr_if.sink    csr_bus
);

   ctl_cmd_type cmd;
   dp_stat_type stat;
   logic        req_ready;

   // sequencer: owns the request handshake
   lpct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table, comparator lanes, response register
   lpct_datapath #(
      .ENTRIES   (ENTRIES),
      .LINE_BITS (LINE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_bus.req_type),
      .predicted_addr (req_bus.predicted_addr),
      .actual_addr    (req_bus.actual_addr),
      .producer_uop   (req_bus.producer_uop),
      .load_number    (req_bus.load_number),
      .csr_valid      (csr_bus.valid),
      .csr_data       (csr_bus.fusion_distance),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_status     (rsp_bus.status),
      .rsp_removed    (rsp_bus.removed_count),
      .rsp_live       (rsp_bus.live_count)
   );

   assign req_bus.ready = req_ready;
   // register writes go straight into dist_ff, no back-pressure
   assign csr_bus.ready = 1'b1;

endmodule

@@ hdl/lpct_ctrl.sv @@
// ============================================================================
// lpct_ctrl
// Request sequencer: compare, resolve, optional count sweep, respond.
// ============================================================================
module lpct_ctrl import lpct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_COMPARE,
      S_RESOLVE,
      S_SWEEP,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = S_RESOLVE;
         end
         S_RESOLVE: begin
            cmd.resolve = 1'b1;
            if (stat.bulk) begin
               state_in = S_SWEEP;
            end else if (stat.slot_free) begin
               // result goes out now; next request may enter alongside
               cmd.push  = 1'b1;
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = S_COMPARE;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.slot_free) begin
               cmd.push  = 1'b1;
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = S_COMPARE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/lpct_datapath.sv @@
// ============================================================================
// lpct_datapath
// Entry table, per-entry comparators, update logic and response register.
// ============================================================================
module lpct_datapath import lpct_pkg::*; #(
   parameter int ENTRIES   = DEFAULT_ENTRIES,
   parameter int LINE_BITS = DEFAULT_LINE_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         cmd,
   output dp_stat_type         stat,
   // request payload
   input  logic [OP_W-1:0]     req_type,
   input  logic [ADDR_W-1:0]   predicted_addr,
   input  logic [ADDR_W-1:0]   actual_addr,
   input  logic [UOP_W-1:0]    producer_uop,
   input  logic [LNUM_W-1:0]   load_number,
   // register write
   input  logic                csr_valid,
   input  logic [DIST_W-1:0]   csr_data,
   // response
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_removed,
   output logic [COUNT_W-1:0]  rsp_live
);

   localparam int BLK_W  = ADDR_W - LINE_BITS;
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CHUNKS = (ENTRIES + CHUNK_W - 1) / CHUNK_W;
   localparam int KILL_W = CHUNKS * CHUNK_W;
   localparam int SWC_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam logic [SWC_W-1:0] SWEEP_FIRST = SWC_W'(CHUNKS - 1);

   // lowest set bit
   function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (v[i]) idx = IDX_W'(i);
      end
      return idx;
   endfunction

   function automatic logic [COUNT_W-1:0] to_out(input logic [CNT_W-1:0] c);
      logic [CNT_W+COUNT_W-1:0] wide;
      wide = {{COUNT_W{1'b0}}, c};
      return wide[COUNT_W-1:0];
   endfunction

   // request registers
   req_op_type          rq_type_ff;
   logic [ADDR_W-1:0]   rq_pred_ff;
   logic [ADDR_W-1:0]   rq_act_ff;
   logic [UOP_W-1:0]    rq_uop_ff;
   logic [LNUM_W-1:0]   rq_lnum_ff;

   logic [DIST_W-1:0]   dist_ff;

   // entry table
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [BLK_W-1:0]    blk_ff  [ENTRIES];
   logic [UOP_W-1:0]    uop_ff  [ENTRIES];
   logic [LNUM_W-1:0]   lnum_ff [ENTRIES];
   logic [CNT_W-1:0]    live_ff, live_in;

   // compare results
   logic [ENTRIES-1:0]  blk_hit, full_hit, stale;
   logic [ENTRIES-1:0]  blk_vec_ff, hit_vec_ff, stale_vec_ff;
   logic                wrong_ff;

   logic [BLK_W-1:0]    pred_blk, act_blk, key_blk;

   // resolve / sweep
   logic                hit_any, free_any, uop_zero;
   logic [IDX_W-1:0]    hit_idx, free_idx, wr_idx;
   logic                wr_all, wr_lnum;
   logic [KILL_W-1:0]   kill_ff, kill_in;
   logic [SWC_W-1:0]    swc_ff, swc_in;
   logic [CNT_W-1:0]    acc_ff, acc_in;
   rsp_status_type      status_ff, status_in;
   logic [PC_W-1:0]     pc;

   // response register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_removed_ff, rsp_live_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rq_type_ff <= req_op_type'(req_type);
         rq_pred_ff <= predicted_addr;
         rq_act_ff  <= actual_addr;
         rq_uop_ff  <= producer_uop;
         rq_lnum_ff <= load_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= DIST_RESET;
      end else if (csr_valid) begin
         dist_ff <= csr_data;
      end
   end

   assign pred_blk = rq_pred_ff[ADDR_W-1:LINE_BITS];
   assign act_blk  = rq_act_ff[ADDR_W-1:LINE_BITS];
   assign key_blk  = (rq_type_ff == OP_CHECK) ? act_blk : pred_blk;

   // one comparator lane per entry
   always_comb begin
      logic [LNUM_W-1:0] gap;
      for (int i = 0; i < ENTRIES; i++) begin
         gap         = rq_lnum_ff - lnum_ff[i];
         blk_hit[i]  = valid_ff[i] && (blk_ff[i] == key_blk);
         full_hit[i] = blk_hit[i] && (uop_ff[i] == rq_uop_ff);
         stale[i]    = valid_ff[i] && (gap > {{(LNUM_W-DIST_W){1'b0}}, dist_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         blk_vec_ff   <= blk_hit;
         hit_vec_ff   <= full_hit;
         stale_vec_ff <= stale;
         wrong_ff     <= (rq_pred_ff != '0) && (pred_blk != act_blk);
      end
   end

   assign hit_any  = |hit_vec_ff;
   assign hit_idx  = first_set(hit_vec_ff);
   assign free_any = ~&valid_ff;
   assign free_idx = first_set(~valid_ff);
   assign uop_zero = (rq_uop_ff == '0);

   always_comb begin
      pc = '0;
      for (int i = 0; i < CHUNK_W; i++) begin
         pc = pc + PC_W'(kill_ff[i]);
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      live_in   = live_ff;
      acc_in    = acc_ff;
      status_in = status_ff;
      kill_in   = kill_ff;
      swc_in    = swc_ff;
      wr_all    = 1'b0;
      wr_lnum   = 1'b0;
      wr_idx    = hit_idx;
      if (cmd.resolve) begin
         acc_in = '0;
         case (rq_type_ff)
            OP_INSERT: begin
               if (hit_any) begin
                  wr_lnum   = 1'b1;
                  status_in = ST_REFRESHED;
               end else if (free_any) begin
                  wr_idx             = free_idx;
                  wr_all             = 1'b1;
                  wr_lnum            = 1'b1;
                  valid_in[free_idx] = 1'b1;
                  live_in            = live_ff + CNT_W'(1);
                  status_in          = ST_INSERTED;
               end else begin
                  status_in = ST_FULL;
               end
            end
            OP_CHECK: begin
               if (hit_any) begin
                  valid_in[hit_idx] = 1'b0;
                  live_in           = live_ff - CNT_W'(1);
                  acc_in            = CNT_W'(1);
                  status_in         = ST_MATCH;
               end else if (wrong_ff) begin
                  status_in = ST_WRONG_BLOCK;
               end else begin
                  status_in = ST_NO_ENTRY;
               end
            end
            OP_INVALIDATE: begin
               status_in = ST_REMOVED;
               if (uop_zero) begin
                  valid_in = valid_ff & ~blk_vec_ff;
                  kill_in  = KILL_W'(blk_vec_ff);
                  swc_in   = SWEEP_FIRST;
               end else if (hit_any) begin
                  valid_in[hit_idx] = 1'b0;
                  live_in           = live_ff - CNT_W'(1);
                  acc_in            = CNT_W'(1);
               end
            end
            OP_CLEANUP: begin
               status_in = ST_REMOVED;
               valid_in  = valid_ff & ~stale_vec_ff;
               kill_in   = KILL_W'(stale_vec_ff);
               swc_in    = SWEEP_FIRST;
            end
            default: begin
               status_in = ST_REMOVED;
            end
         endcase
      end else if (cmd.sweep) begin
         acc_in  = acc_ff + CNT_W'(pc);
         kill_in = kill_ff >> CHUNK_W;
         swc_in  = swc_ff - SWC_W'(1);
         if (swc_ff == '0) begin
            live_in = live_ff - acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         live_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         live_ff  <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      status_ff <= status_in;
      kill_ff   <= kill_in;
      swc_ff    <= swc_in;
   end

   always_ff @(posedge clock) begin
      if (wr_all) begin
         blk_ff[wr_idx] <= pred_blk;
         uop_ff[wr_idx] <= rq_uop_ff;
      end
      if (wr_lnum) begin
         lnum_ff[wr_idx] <= rq_lnum_ff;
      end
   end

   assign stat.bulk       = (rq_type_ff == OP_CLEANUP) ||
                            ((rq_type_ff == OP_INVALIDATE) && uop_zero);
   assign stat.sweep_last = (swc_ff == '0);
   assign stat.slot_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_status_ff  <= status_in;
         rsp_removed_ff <= to_out(acc_in);
         rsp_live_ff    <= to_out(live_in);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_removed = rsp_removed_ff;
   assign rsp_live    = rsp_live_ff;

endmodule

@@ test/lpct_table_checker.sv @@
// ============================================================================
// lpct_table_checker
// Watches the request, response and CSR channels of the load prediction
// check table. Keeps its own copy of the table and of fusion_distance,
// works out the result of every accepted request and compares each
// response transfer with the oldest outstanding one.
// ============================================================================
module lpct_table_checker import lpct_pkg::*; #(
   parameter int ENTRIES   = DEFAULT_ENTRIES,
   parameter int LINE_BITS = DEFAULT_LINE_BITS
) (
   input  logic  clock,
   input  logic  reset,
   lpct_req_if   req_bus,
   lpct_rsp_if   rsp_bus,
   lpct_csr_if   csr_bus,
   output int    mismatch_count,
   output int    pending_results
);

   localparam int BLOCK_W = ADDR_W - LINE_BITS;

   typedef struct packed {
      rsp_status_type      status;
      logic [COUNT_W-1:0]  removed;
      logic [COUNT_W-1:0]  live;
   } table_result_type;

   logic               slot_valid [ENTRIES];
   logic [BLOCK_W-1:0] slot_block [ENTRIES];
   logic [UOP_W-1:0]   slot_uop   [ENTRIES];
   logic [LNUM_W-1:0]  slot_lnum  [ENTRIES];
   int                 live_total;
   logic [DIST_W-1:0]  distance;
   table_result_type   promised_q [$];

   function automatic logic [BLOCK_W-1:0] block_of(input logic [ADDR_W-1:0] addr);
      return addr[ADDR_W-1:LINE_BITS];
   endfunction

   // lowest valid slot holding (block, uop), -1 if none
   function automatic int find_slot(input logic [BLOCK_W-1:0] blk,
                                    input logic [UOP_W-1:0] uop);
      int hit;
      hit = -1;
      for (int i = ENTRIES - 1; i >= 0; i--)
         if (slot_valid[i] && slot_block[i] == blk && slot_uop[i] == uop)
            hit = i;
      return hit;
   endfunction

   function automatic void drop_slot(input int i);
      slot_valid[i] = 1'b0;
      if (live_total > 0)
         live_total--;
   endfunction

   function automatic table_result_type apply_request(
      input req_op_type          op,
      input logic [ADDR_W-1:0]   pred,
      input logic [ADDR_W-1:0]   act,
      input logic [UOP_W-1:0]    uop,
      input logic [LNUM_W-1:0]   lnum
   );
      table_result_type   res;
      int                 hit;
      int                 removed;
      bit                 placed;
      logic [BLOCK_W-1:0] blk;
      logic [LNUM_W-1:0]  gap;
      res.status = ST_REMOVED;
      removed    = 0;
      case (op)
         OP_INSERT: begin
            blk = block_of(pred);
            hit = find_slot(blk, uop);
            if (hit >= 0) begin
               slot_lnum[hit] = lnum;
               res.status     = ST_REFRESHED;
            end else begin
               res.status = ST_FULL;
               placed     = 1'b0;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (!placed && !slot_valid[i]) begin
                     placed        = 1'b1;
                     slot_valid[i] = 1'b1;
                     slot_block[i] = blk;
                     slot_uop[i]   = uop;
                     slot_lnum[i]  = lnum;
                     live_total++;
                     res.status    = ST_INSERTED;
                  end
               end
            end
         end
         OP_CHECK: begin
            blk = block_of(act);
            hit = find_slot(blk, uop);
            if (hit >= 0) begin
               drop_slot(hit);
               removed    = 1;
               res.status = ST_MATCH;
            end else if (pred != '0 && block_of(pred) != blk) begin
               res.status = ST_WRONG_BLOCK;
            end else begin
               res.status = ST_NO_ENTRY;
            end
         end
         OP_INVALIDATE: begin
            blk = block_of(pred);
            if (uop != '0) begin
               hit = find_slot(blk, uop);
               if (hit >= 0) begin
                  drop_slot(hit);
                  removed = 1;
               end
            end else begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot_valid[i] && slot_block[i] == blk) begin
                     drop_slot(i);
                     removed++;
                  end
               end
            end
         end
         default: begin
            for (int i = 0; i < ENTRIES; i++) begin
               gap = lnum - slot_lnum[i];
               if (slot_valid[i] && gap > LNUM_W'(distance)) begin
                  drop_slot(i);
                  removed++;
               end
            end
         end
      endcase
      res.removed = COUNT_W'(removed);
      res.live    = COUNT_W'(live_total);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      table_result_type want;
      logic             bad;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++)
            slot_valid[i] = 1'b0;
         live_total = 0;
         distance   = DIST_RESET;
         promised_q.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready)
            distance = csr_bus.fusion_distance;
         if (req_bus.valid && req_bus.ready)
            promised_q.push_back(apply_request(req_op_type'(req_bus.req_type),
                                               req_bus.predicted_addr,
                                               req_bus.actual_addr,
                                               req_bus.producer_uop,
                                               req_bus.load_number));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (promised_q.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatch_count++;
            end else begin
               want = promised_q.pop_front();
               bad  = 1'b0;
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  bad = 1'b1;
               end
               if (rsp_bus.removed_count !== want.removed) begin
                  $error("removed_count: expected %0d, got %0d",
                         want.removed, rsp_bus.removed_count);
                  bad = 1'b1;
               end
               if (rsp_bus.live_count !== want.live) begin
                  $error("live_count: expected %0d, got %0d",
                         want.live, rsp_bus.live_count);
                  bad = 1'b1;
               end
               if (bad)
                  mismatch_count++;
            end
         end
      end
      pending_results = promised_q.size();
   end

endmodule

@@ test/load_prediction_check_table_tb.sv @@
// ============================================================================
// load_prediction_check_table_tb
// Drives the load prediction check table with a short directed sequence and
// then phases of random requests under several fusion_distance settings,
// with bursty requests and a stalling response side. Checking is done by
// lpct_table_checker; this module only makes stimulus and gives the verdict.
// ============================================================================
module load_prediction_check_table_tb;
   import lpct_pkg::*;

   localparam int                POOL        = 6;
   localparam int                HOLD_CYCLES = 120;   // long response stall
   localparam int                FILL_COUNT  = 68;    // more than ENTRIES
   localparam int                SETTLE      = 24;    // quiet time after results drain
   localparam logic [ADDR_W-1:0] LINE_MASK   = (64'd1 << DEFAULT_LINE_BITS) - 64'd1;

   logic clock;
   logic reset;

   lpct_req_if req_bus ();
   lpct_rsp_if rsp_bus ();
   lpct_csr_if csr_bus ();

   int mismatch_count;
   int pending_results;

   load_prediction_check_table dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   lpct_table_checker table_check (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_bus         (csr_bus),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   // ------------------------------------------------------------------------
   // stimulus-side state (shapes requests only, predicts nothing)
   // ------------------------------------------------------------------------
   int                burst_left;      // transfers left in current burst
   bit                hold_wanted;     // ask receiver for its long stall
   logic [DIST_W-1:0] gap_limit;       // fusion_distance last written
   logic [LNUM_W-1:0] lnum_clock;      // running load number, wraps early
   logic [ADDR_W-1:0] pool_block [POOL];
   logic [UOP_W-1:0]  pool_uop   [POOL];
   logic [ADDR_W-1:0] recent_addr [$]; // keys inserted lately, to aim hits
   logic [UOP_W-1:0]  recent_uop  [$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard limit on the whole run
   initial begin
      #2_000_000;
      $display("load_prediction_check_table_tb NOT OK");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [ADDR_W-1:0] low_bits();
      return ADDR_W'($urandom()) & LINE_MASK;
   endfunction

   function automatic void remember(input logic [ADDR_W-1:0] a, input logic [UOP_W-1:0] u);
      recent_addr.push_back(a);
      recent_uop.push_back(u);
      if (recent_addr.size() > 48) begin
         void'(recent_addr.pop_front());
         void'(recent_uop.pop_front());
      end
   endfunction

   // One request transfer. Called at a falling edge, returns at one.
   // Valid stays high across a burst; a burst ends with a gap with valid low.
   task automatic send_request(input req_op_type        op,
                               input logic [ADDR_W-1:0] pred,
                               input logic [ADDR_W-1:0] act,
                               input logic [UOP_W-1:0]  uop,
                               input logic [LNUM_W-1:0] lnum);
      if (burst_left == 0)
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      req_bus.valid          <= 1'b1;
      req_bus.req_type       <= op;
      req_bus.predicted_addr <= pred;
      req_bus.actual_addr    <= act;
      req_bus.producer_uop   <= uop;
      req_bus.load_number    <= lnum;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      burst_left--;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   // Stop offering, let every outstanding result come back, then give the
   // block time to finish any sweep in flight.
   task automatic quiesce();
      if (burst_left != 0) begin
         req_bus.valid <= 1'b0;
         burst_left = 0;
         @(negedge clock);
      end
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_distance(input logic [DIST_W-1:0] value);
      csr_bus.valid           <= 1'b1;
      csr_bus.fusion_distance <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      gap_limit = value;
   endtask

   // Mostly well-formed traffic on a small pool of blocks and micro-ops so
   // that refreshes, hits and removals are common; the rest is raw noise.
   task automatic random_request();
      int                pick;
      int                k;
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] p;
      logic [UOP_W-1:0]  u;
      logic [LNUM_W-1:0] n;
      pick = $urandom_range(0, 99);
      a    = pool_block[$urandom_range(0, POOL - 1)] | low_bits();
      u    = pool_uop[$urandom_range(0, POOL - 1)];
      if (recent_addr.size() != 0 && $urandom_range(0, 3) != 0) begin
         k = $urandom_range(0, recent_addr.size() - 1);
         a = recent_addr[k] ^ low_bits();
         u = recent_uop[k];
      end
      if (pick < 40) begin
         // insert; fresh keys now and then, micro-op zero now and then
         if ($urandom_range(0, 4) == 0)
            a = pool_block[$urandom_range(0, POOL - 1)] | low_bits();
         if ($urandom_range(0, 9) == 0)
            u = '0;
         n = lnum_clock + LNUM_W'($urandom_range(0, 3));
         lnum_clock += LNUM_W'($urandom_range(0, 4));
         remember(a, u);
         send_request(OP_INSERT, a, rand64(), u, n);
      end else if (pick < 70) begin
         // check: predicted address zero, same block, or elsewhere
         case ($urandom_range(0, 2))
            0:       p = '0;
            1:       p = a ^ low_bits();
            default: p = rand64();
         endcase
         send_request(OP_CHECK, p, a, u, rand64());
      end else if (pick < 78) begin
         send_request(OP_INVALIDATE, a, rand64(), u, rand64());
      end else if (pick < 82) begin
         // micro-op zero: whole block
         send_request(OP_INVALIDATE, a, rand64(), '0, rand64());
      end else if (pick < 90) begin
         case ($urandom_range(0, 3))
            0:       n = lnum_clock;
            1:       n = lnum_clock + LNUM_W'(gap_limit) - LNUM_W'($urandom_range(0, 4));
            2:       n = lnum_clock - LNUM_W'($urandom_range(0, 100));
            default: n = rand64();
         endcase
         send_request(OP_CLEANUP, rand64(), rand64(), rand64(), n);
      end else begin
         send_request(req_op_type'($urandom_range(0, 3)), rand64(), rand64(),
                      rand64(), rand64());
      end
   endtask

   task automatic run_phase(input logic [DIST_W-1:0] limit_value, input int count,
                            input bit with_fill);
      logic [ADDR_W-1:0] a;
      logic [UOP_W-1:0]  u;
      quiesce();
      write_distance(limit_value);
      if (with_fill) begin
         // receiver holds off while the table overflows: inserts past the
         // last free slot must report full, and the request side backs up
         hold_wanted = 1'b1;
         repeat (FILL_COUNT) begin
            a = rand64();
            u = rand64();
            remember(a, u);
            send_request(OP_INSERT, a, rand64(), u, lnum_clock);
         end
      end
      repeat (count) random_request();
   endtask

   // ------------------------------------------------------------------------
   // response side: changes stall pattern every segment, plus one long hold
   // ------------------------------------------------------------------------
   initial begin : receiver
      int seg_left;
      int mode;
      int beat;
      bit hold_done;
      rsp_bus.ready <= 1'b0;
      seg_left  = 0;
      mode      = 0;
      beat      = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (seg_left == 0) begin
               mode     = $urandom_range(0, 3);
               seg_left = $urandom_range(16, 96);
            end
            seg_left--;
            beat++;
            case (mode)
               0:       rsp_bus.ready <= 1'b1;                   // no stalls
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= (beat % 4) == 0;         // one in four
               default: rsp_bus.ready <= (beat % 16) >= 11;       // long stalls
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // request side and verdict
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [ADDR_W-1:0] ones;
      ones = '1;
      req_bus.valid           <= 1'b0;
      req_bus.req_type        <= OP_INSERT;
      req_bus.predicted_addr  <= '0;
      req_bus.actual_addr     <= '0;
      req_bus.producer_uop    <= '0;
      req_bus.load_number     <= '0;
      csr_bus.valid           <= 1'b0;
      csr_bus.fusion_distance <= '0;
      burst_left  = 0;
      hold_wanted = 1'b0;
      gap_limit   = DIST_RESET;
      lnum_clock  = ones - LNUM_W'($urandom_range(0, 300));  // wraps during run
      for (int k = 0; k < POOL; k++) begin
         pool_block[k] = rand64() & ~LINE_MASK;
         pool_uop[k]   = rand64() | 64'd1;
      end
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, fusion_distance at its reset value
      send_request(OP_CHECK,  '0,   '0,   '0,   '0);     // empty table: no entry
      send_request(OP_INSERT, '0,   ones, '0,   '0);     // block 0, uop 0
      send_request(OP_INSERT, '0,   '0,   '0,   ones);   // same key: refresh
      send_request(OP_INSERT, ones, '0,   ones, 64'd5);
      send_request(OP_INSERT, 64'h3F, '0, 64'd1, 64'd10); // block 0, uop 1
      send_request(OP_CHECK,  '0,   64'h3F, '0, '0);     // hit, consumed
      send_request(OP_CHECK,  '0,   '0,   '0,   '0);     // gone now
      send_request(OP_CHECK,  64'h7F, 64'h40, 64'd7, '0); // same block: no entry
      send_request(OP_CHECK,  64'h80, 64'h40, 64'd7, '0); // other block: wrong
      send_request(OP_CHECK,  64'h3F, 64'h40, 64'd1, '0); // entry sits in pred block
      send_request(OP_CHECK,  ones, ones, ones, ones);   // top block hit
      send_request(OP_INSERT, ones, '0,   ones, 64'd5);
      send_request(OP_INVALIDATE, ones, '0, ones, '0);   // single entry
      send_request(OP_INVALIDATE, '0,   '0, 64'd5, '0);  // nothing matches
      send_request(OP_INSERT, 64'h1000, '0, 64'd1, '0);
      send_request(OP_INSERT, 64'h1008, '0, 64'd2, 64'd64);
      send_request(OP_INSERT, 64'h1030, '0, 64'd3, 64'd100);
      send_request(OP_INVALIDATE, 64'h1010, '0, '0, '0); // whole block, three
      send_request(OP_INSERT, 64'h2000, '0, '0, '0);
      send_request(OP_INSERT, 64'h3000, '0, 64'd9, 64'd64);
      send_request(OP_CLEANUP, '0, '0, '0, 64'd64);       // gap equal to limit kept
      send_request(OP_CLEANUP, '0, '0, '0, 64'd65);       // gap one over removed
      send_request(OP_CLEANUP, '0, '0, '0, '0);           // negative gaps wrap large
      send_request(OP_INVALIDATE, '0, '0, '0, '0);        // empty block sweep

      // random part under several distance settings, extremes included
      run_phase(32'd0,                          60, 1'b0);
      run_phase(32'hFFFF_FFFF,                  60, 1'b1);
      run_phase(DIST_W'($urandom_range(1, 200)), 60, 1'b0);
      run_phase($urandom(),                     60, 1'b0);
      run_phase(32'd1,                          60, 1'b0);

      quiesce();
      if (mismatch_count == 0 && pending_results == 0)
         $display("load_prediction_check_table_tb OK");
      else
         $display("load_prediction_check_table_tb NOT OK");
      $finish;
   end

endmodule

@@ files.f @@
hdl/lpct_pkg.sv
hdl/lpct_if.sv
hdl/lpct_ctrl.sv
hdl/lpct_datapath.sv
hdl/load_prediction_check_table.sv
test/lpct_table_checker.sv
test/load_prediction_check_table_tb.sv
